// ===== hdl/cms_pkg.sv =====
`timescale 1ns / 1ps

package cms_pkg;

	// Table geometry
	localparam int CAPACITY   = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int VALUE_W    = 32;
	localparam int OCC_W      = 16;

	localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};
	localparam logic [IDX_W-1:0]      LAST_IDX    = IDX_W'(CAPACITY - 1);

	// Operation codes
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [VALUE_W-1:0] value;
	} cms_req_t;

	typedef struct packed {
		logic [OCC_W-1:0]          occurrences;
		logic signed [VALUE_W-1:0] largest;
		logic                      is_empty;
		logic [1:0]                status;
	} cms_rsp_t;

	// One table entry as seen on the read port
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [COUNT_BITS-1:0]     count;
		logic                      valid;
	} cms_entry_t;

	// Table write command
	typedef struct packed {
		logic                      en;
		logic                      value_en;
		logic [IDX_W-1:0]          addr;
		logic signed [VALUE_W-1:0] value;
		logic [COUNT_BITS-1:0]     count;
		logic                      valid;
	} cms_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_RESCAN,
		ST_FINISH
	} cms_state_t;

endpackage

// ===== hdl/cms_table.sv =====
`timescale 1ns / 1ps

module cms_table
	import cms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_addr,
	output cms_entry_t       rd,
	output logic             any_valid,
	input  cms_wr_t          wr
);

	logic signed [VALUE_W-1:0] values_q [CAPACITY];
	logic [COUNT_BITS-1:0]     counts_q [CAPACITY];
	logic [CAPACITY-1:0]       valid_q;

	// Values hold no reset: only read under a valid bit
	always_ff @(posedge clk) begin
		if (wr.en && wr.value_en) begin
			values_q[wr.addr] <= wr.value;
		end
	end

	// Counts and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				counts_q[i] <= '0;
			end
			valid_q <= '0;
		end else if (wr.en) begin
			counts_q[wr.addr] <= wr.count;
			valid_q[wr.addr]  <= wr.valid;
		end
	end

	// Single read port
	always_comb begin
		rd.value = values_q[rd_addr];
		rd.count = counts_q[rd_addr];
		rd.valid = valid_q[rd_addr];
	end

	assign any_valid = |valid_q;

endmodule

// ===== hdl/counted_multiset_with_max_top.sv =====
`timescale 1ns / 1ps
// A request steps through a scan of the table, an update and a finish state before the done strobe;
// a remove that frees an entry adds a full maximum rescan between the update and the finish.
// The block takes no new request while busy, which is high from acceptance until the strobe.
// One shared comparator steps through the table one entry a cycle.
// The result is on rsp for the single done cycle; the receiver cannot stall.
// Reset (arst_n low, asynchronous) empties the table and clears the maximum.

module counted_multiset_with_max_top
	import cms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cms_req_t req,
	output logic     done,
	output cms_rsp_t rsp
);

	cms_state_t state_q, state_d;

	cms_req_t                  req_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      hit_q;
	logic [IDX_W-1:0]          hit_idx_q;
	logic                      free_q;
	logic [IDX_W-1:0]          free_idx_q;
	logic                      seen_q;
	logic signed [VALUE_W-1:0] max_q;
	logic [COUNT_BITS-1:0]     occ_q;
	logic [1:0]                status_q;
	logic                      done_q;
	cms_rsp_t                  rsp_q;

	logic [IDX_W-1:0]          rd_addr;
	cms_entry_t                rd;
	logic                      any_valid;
	cms_wr_t                   wr;

	logic signed [VALUE_W-1:0] cmp_b;
	logic                      cmp_eq;
	logic                      cmp_gt;

	logic [COUNT_BITS-1:0]     occ_d;
	logic [1:0]                status_d;
	logic                      free_entry;
	logic                      new_max;
	logic                      last_idx;

	cms_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_addr   (rd_addr),
		.rd        (rd),
		.any_valid (any_valid),
		.wr        (wr)
	);

	// Shared comparator: match against key while scanning, against max while rescanning
	assign cmp_b  = (state_q == ST_RESCAN) ? max_q : req_q.value;
	assign cmp_eq = (rd.value == cmp_b);
	assign cmp_gt = (rd.value > cmp_b);

	assign last_idx = (idx_q == LAST_IDX);
	assign rd_addr  = (state_q == ST_UPDATE) ? hit_idx_q : idx_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_idx) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = free_entry ? ST_RESCAN : ST_FINISH;
			end
			ST_RESCAN: begin
				if (last_idx) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: operation decode and table write
	always_comb begin
		busy       = (state_q != ST_IDLE);
		wr         = '0;
		occ_d      = '0;
		status_d   = STAT_OK;
		free_entry = 1'b0;
		new_max    = 1'b0;
		if (state_q == ST_UPDATE) begin
			unique case (req_q.kind)
				KIND_ADD: begin
					if (hit_q) begin
						if (rd.count == COUNT_LIMIT) begin
							status_d = STAT_SAT;
							occ_d    = rd.count;
						end else begin
							wr.en    = 1'b1;
							wr.addr  = hit_idx_q;
							wr.count = rd.count + 1'b1;
							wr.valid = 1'b1;
							occ_d    = rd.count + 1'b1;
						end
					end else if (free_q) begin
						wr.en       = 1'b1;
						wr.value_en = 1'b1;
						wr.addr     = free_idx_q;
						wr.value    = req_q.value;
						wr.count    = COUNT_BITS'(1);
						wr.valid    = 1'b1;
						occ_d       = COUNT_BITS'(1);
						new_max     = !any_valid || (req_q.value > max_q);
					end else begin
						status_d = STAT_FULL;
					end
				end
				KIND_REMOVE: begin
					if (hit_q) begin
						wr.en   = 1'b1;
						wr.addr = hit_idx_q;
						if (rd.count <= COUNT_BITS'(1)) begin
							wr.count   = '0;
							wr.valid   = 1'b0;
							free_entry = 1'b1;
						end else begin
							wr.count = rd.count - 1'b1;
							wr.valid = 1'b1;
							occ_d    = rd.count - 1'b1;
						end
					end
				end
				default: begin
					if (hit_q) occ_d = rd.count;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			max_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH);
			if (state_q == ST_UPDATE) begin
				if (new_max) max_q <= req_q.value;
				else if (free_entry) max_q <= '0;
			end else if (state_q == ST_RESCAN) begin
				if (rd.valid && (!seen_q || cmp_gt)) max_q <= rd.value;
			end
		end
	end

	// Scan datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q  <= req;
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			ST_SCAN: begin
				idx_q <= idx_q + 1'b1;
				if (rd.valid && cmp_eq && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_q;
				end
				if (!rd.valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_q;
				end
			end
			ST_UPDATE: begin
				idx_q    <= '0;
				seen_q   <= 1'b0;
				occ_q    <= occ_d;
				status_q <= status_d;
			end
			ST_RESCAN: begin
				idx_q <= idx_q + 1'b1;
				if (rd.valid) seen_q <= 1'b1;
			end
			ST_FINISH: begin
				rsp_q.occurrences <= OCC_W'(occ_q);
				rsp_q.largest     <= any_valid ? max_q : '0;
				rsp_q.is_empty    <= !any_valid;
				rsp_q.status      <= status_q;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== bench/cms_checker.sv =====
`timescale 1ns / 1ps

module cms_checker
	import cms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  cms_req_t req,
	input  logic     done,
	input  cms_rsp_t rsp,
	output int       fails,
	output int       pending
);

	// Shadow copy of the table
	logic signed [VALUE_W-1:0] slot_value [CAPACITY];
	logic [COUNT_BITS-1:0]     slot_count [CAPACITY];
	logic                      slot_used  [CAPACITY];
	logic signed [VALUE_W-1:0] peak;

	// Results still owed by the block, oldest first
	cms_rsp_t owed_rsp [$];

	function automatic int find_slot(input logic signed [VALUE_W-1:0] v);
		int i;
		for (i = 0; i < CAPACITY; i++)
			if (slot_used[i] && slot_value[i] == v)
				return i;
		return -1;
	endfunction

	function automatic int free_slot();
		int i;
		for (i = 0; i < CAPACITY; i++)
			if (!slot_used[i])
				return i;
		return -1;
	endfunction

	function automatic logic table_empty();
		int i;
		for (i = 0; i < CAPACITY; i++)
			if (slot_used[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Full maximum rescan after an entry is freed; 0 when nothing is left
	function automatic void rescan_peak();
		int  i;
		logic seen;
		seen = 1'b0;
		peak = '0;
		for (i = 0; i < CAPACITY; i++) begin
			if (slot_used[i] && (!seen || slot_value[i] > peak)) begin
				peak = slot_value[i];
				seen = 1'b1;
			end
		end
	endfunction

	// Apply one request to the shadow table and return the result it should give
	function automatic cms_rsp_t apply_request(input cms_req_t r);
		cms_rsp_t              res;
		int                    idx;
		int                    slot;
		logic                  was_empty;
		logic [COUNT_BITS-1:0] occ;
		res       = '0;
		occ       = '0;
		res.status = STAT_OK;
		idx       = find_slot(r.value);
		if (r.kind == KIND_ADD) begin
			if (idx >= 0) begin
				if (slot_count[idx] == COUNT_LIMIT)
					res.status = STAT_SAT;
				else
					slot_count[idx] = slot_count[idx] + 1'b1;
				occ = slot_count[idx];
			end else begin
				slot = free_slot();
				if (slot < 0) begin
					res.status = STAT_FULL;
				end else begin
					was_empty        = table_empty();
					slot_value[slot] = r.value;
					slot_count[slot] = COUNT_BITS'(1);
					slot_used[slot]  = 1'b1;
					if (was_empty || r.value > peak)
						peak = r.value;
					occ = COUNT_BITS'(1);
				end
			end
		end else if (r.kind == KIND_REMOVE) begin
			if (idx >= 0) begin
				if (slot_count[idx] <= 1) begin
					slot_count[idx] = '0;
					slot_used[idx]  = 1'b0;
					rescan_peak();
					occ = '0;
				end else begin
					slot_count[idx] = slot_count[idx] - 1'b1;
					occ = slot_count[idx];
				end
			end
		end else begin
			// query, and the spare kind code behaves the same
			if (idx >= 0)
				occ = slot_count[idx];
		end
		res.occurrences = OCC_W'(occ);
		res.is_empty    = table_empty();
		res.largest     = res.is_empty ? '0 : peak;
		return res;
	endfunction

	// Watch both channels: retire a strobed result, then log an accepted request
	always @(posedge clk or negedge arst_n) begin
		cms_rsp_t want;
		int       errs;
		errs = 0;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				slot_value[i] = '0;
				slot_count[i] = '0;
				slot_used[i]  = 1'b0;
			end
			peak = '0;
			owed_rsp.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (owed_rsp.size() == 0) begin
					$error("result strobed with no request outstanding");
					errs++;
				end else begin
					want = owed_rsp.pop_front();
					if (rsp.occurrences !== want.occurrences) begin
						$error("occurrences: expected %0d, got %0d",
							want.occurrences, rsp.occurrences);
						errs++;
					end
					if (rsp.largest !== want.largest) begin
						$error("largest: expected %0d, got %0d", want.largest, rsp.largest);
						errs++;
					end
					if (rsp.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d", want.is_empty, rsp.is_empty);
						errs++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errs++;
					end
				end
			end
			if (start && !busy)
				owed_rsp.insert(owed_rsp.size(), apply_request(req));
			pending <= owed_rsp.size();
			fails   <= fails + errs;
		end
	end

endmodule

// ===== bench/counted_multiset_with_max_top_tb.sv =====
`timescale 1ns / 1ps

module counted_multiset_with_max_top_tb;
	import cms_pkg::*;

	// The one kind code the block does not name; it acts as a query
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 320;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	cms_req_t req    = '0;
	logic     busy;
	logic     done;
	cms_rsp_t rsp;
	int       fails;
	int       pending;

	logic signed [VALUE_W-1:0] value_pool [$];

	counted_multiset_with_max_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	cms_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#(80_000_000);
		$display("TB_ERROR");
		$finish;
	end

	// Hold a request until the block takes it; start stays high on return
	task automatic issue(input logic [1:0] k, input logic signed [VALUE_W-1:0] v);
		start    <= 1'b1;
		req.kind  <= k;
		req.value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Sender gap after an accepted request; a zero gap keeps start high
	task automatic hold_off(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// Stop sending until every owed result is back
	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// New working set of values for one phase
	task automatic build_pool(input int n);
		int r;
		logic signed [VALUE_W-1:0] v;
		value_pool.delete();
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 30)
				v = $urandom_range(40);
			else if (r < 45)
				v = -$signed({1'b0, 31'($urandom_range(40, 2))});
			else if (r < 55)
				case ($urandom_range(3))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = VAL_MIN + 1;
					default: v = VAL_MAX - 1;
				endcase
			else
				v = $urandom;
			value_pool.insert(value_pool.size(), v);
		end
	endtask

	initial begin
		int add_pct [PHASES];
		int rem_pct [PHASES];
		int pool_sz [PHASES];
		int r;
		int waited;
		logic [1:0] k;
		logic signed [VALUE_W-1:0] v;

		add_pct = '{35, 55, 45, 60, 40, 50};
		rem_pct = '{50, 30, 40, 25, 45, 35};
		pool_sz = '{8, 20, 6, 24, 40, 12};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, rescan on free, full table
		issue(KIND_QUERY, 5);
		issue(KIND_REMOVE, 5);
		issue(KIND_ADD, VAL_MIN);
		issue(KIND_ADD, VAL_MAX);
		issue(KIND_ADD, VAL_MIN);
		issue(KIND_SPARE, VAL_MAX);
		issue(KIND_REMOVE, VAL_MAX);
		issue(KIND_REMOVE, VAL_MIN);
		issue(KIND_REMOVE, VAL_MIN);
		issue(KIND_ADD, -1);
		for (int i = 0; i < CAPACITY - 1; i++)
			issue(KIND_ADD, i);
		issue(KIND_ADD, 100);
		issue(KIND_REMOVE, 7);
		issue(KIND_ADD, 100);
		wait_quiet();

		// Repeated adds and removes on one stored value
		issue(KIND_ADD, -1);
		issue(KIND_REMOVE, -1);
		issue(KIND_ADD, -1);
		issue(KIND_ADD, -1);
		issue(KIND_QUERY, -1);
		wait_quiet();

		// Random phases over shifting working sets
		for (int ph = 0; ph < PHASES; ph++) begin
			build_pool(pool_sz[ph]);
			if (ph == 0)
				for (int i = 0; i < CAPACITY - 1; i++)
					value_pool.insert(value_pool.size(), i);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < add_pct[ph])
					k = KIND_ADD;
				else if (r < add_pct[ph] + rem_pct[ph])
					k = KIND_REMOVE;
				else if ($urandom_range(3) == 0)
					k = KIND_SPARE;
				else
					k = KIND_QUERY;
				if ($urandom_range(9) == 0)
					v = $urandom;
				else
					v = value_pool[$urandom_range(value_pool.size() - 1)];
				issue(k, v);
				// one phase runs back to back
				if (ph != 2)
					hold_off(gap_len());
			end
			wait_quiet();
		end

		// Drain and let any stray strobe show up
		start  <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		if (pending != 0)
			$error("%0d results never arrived", pending);
		if (fails == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
